// ===== hw/rtl/vita49_packet_deframer_defines.svh =====
// assertion macros shared by the deframer rtl files
// expects i_clk and i_rst_n in the scope of each use
`ifndef VITA49_PACKET_DEFRAMER_DEFINES_SVH
`define VITA49_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vpd_pkg.sv =====
// shared types, field codes and register indexes of the packet deframer
// no dependencies
package vpd_pkg;

    localparam int unsigned MAX_PACKET_WORDS_DEF = 16384;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned KIND_W      = 5;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned OUT_DATA_W  = VALUE_W + 2 * SAMPLE_W;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned PKT_LEN_W   = 17;
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int unsigned RES_CNT_W   = RES_IDX_W + 1;
    localparam int unsigned SAMPLES_W   = 14;

    // field kinds carried on tuser
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_ALIGN      = 5'd0;
    localparam t_kind KIND_FRAME_CNT  = 5'd1;
    localparam t_kind KIND_FRAME_SIZE = 5'd2;
    localparam t_kind KIND_TYPE       = 5'd3;
    localparam t_kind KIND_CLASS_FLAG = 5'd4;
    localparam t_kind KIND_TRAIL_FLAG = 5'd5;
    localparam t_kind KIND_TSI_TYPE   = 5'd6;
    localparam t_kind KIND_TSF_TYPE   = 5'd7;
    localparam t_kind KIND_PKT_CNT    = 5'd8;
    localparam t_kind KIND_PKT_SIZE   = 5'd9;
    localparam t_kind KIND_STREAM     = 5'd10;
    localparam t_kind KIND_OUI        = 5'd11;
    localparam t_kind KIND_ICC        = 5'd12;
    localparam t_kind KIND_PCC        = 5'd13;
    localparam t_kind KIND_TS_INT     = 5'd14;
    localparam t_kind KIND_TS_FRAC    = 5'd15;
    localparam t_kind KIND_SAMPLE     = 5'd16;
    localparam t_kind KIND_TRAILER    = 5'd17;
    localparam t_kind KIND_END        = 5'd18;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DECODE_MODE   = 3'd0;
    localparam t_cfg_idx CFG_HEADER_BYTES  = 3'd1;
    localparam t_cfg_idx CFG_PAYLOAD_BYTES = 3'd2;
    localparam t_cfg_idx CFG_TAIL_BYTES    = 3'd3;
    localparam t_cfg_idx CFG_BYTE_SWAP     = 3'd4;
    localparam t_cfg_idx CFG_IQ_SWAP       = 3'd5;

    // decode modes, code 3 behaves as framed
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_RAW    = 2'd0;
    localparam t_mode MODE_FRAMED = 2'd1;
    localparam t_mode MODE_PLAIN  = 2'd2;

    typedef struct packed {
        t_mode       decode_mode;
        logic [8:0]  header_bytes;
        logic [15:0] payload_bytes;
        logic [8:0]  tail_bytes;
        logic        byte_swap;
        logic        iq_swap;
    } t_cfg;

    // all results caused by one packet word
    typedef struct packed {
        logic                                load;
        logic [RES_IDX_W-1:0]                last_idx;
        logic [MAX_RESULTS-1:0][KIND_W-1:0]  kind;
        logic [MAX_RESULTS-1:0][VALUE_W-1:0] value;
        logic signed [SAMPLE_W-1:0]          sample_i;
        logic signed [SAMPLE_W-1:0]          sample_q;
    } t_bundle;

    function automatic logic [WORD_W-1:0] f_byte_swap(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ===== hw/rtl/vita49_packet_deframer.sv =====
// Packet deframer for VITA-49 and raw I/Q streams. Packet words enter on the s_axis side one
// per beat; each word is decoded in a single registered pass into up to eight tagged results,
// which leave on m_axis one per beat with tuser giving the field kind and tlast closing the
// results of one input word. Words with at most one result, such as samples, pass at one word
// per clock while m_axis_tready is high; a word with n results holds the output serialiser
// until all n are taken (a VITA header word yields seven, eight at packet end), and the input
// side stalls behind it. The input ready comes from a skid register, so a held output beat
// never blocks the word behind it in the same cycle. Configuration is written through the i_cfg
// port, which the user must do only while no packet results are pending; the block does not
// enforce this. The packet length is re-registered from the configuration every cycle.
// depends on vpd_pkg, vpd_in_skid, vpd_decode, vpd_out_emit
module vita49_packet_deframer #(
    parameter int unsigned MAX_PACKET_WORDS = vpd_pkg::MAX_PACKET_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [vpd_pkg::WORD_W-1:0]     s_axis_tdata,   // [31:0] data_word
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [63:0] field_value, [79:64] sample_i, [95:80] sample_q
    output logic [vpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [vpd_pkg::KIND_W-1:0]     m_axis_tuser,   // [4:0] field_kind
    output logic                           m_axis_tlast    // last_of_run
);
    import vpd_pkg::*;

    t_cfg                 r_cfg;
    logic [PKT_LEN_W-1:0] r_pkt_words;
    logic [PKT_LEN_W-1:0] n_pkt_words;
    logic [PKT_LEN_W-1:0] bytes;
    logic [PKT_LEN_W-1:0] words;

    logic              word_valid;
    logic [WORD_W-1:0] word;
    logic              word_ready;
    t_bundle           bun;
    logic              bun_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DECODE_MODE:   r_cfg.decode_mode   <= i_cfg_data[1:0];
                CFG_HEADER_BYTES:  r_cfg.header_bytes  <= i_cfg_data[8:0];
                CFG_PAYLOAD_BYTES: r_cfg.payload_bytes <= i_cfg_data[15:0];
                CFG_TAIL_BYTES:    r_cfg.tail_bytes    <= i_cfg_data[8:0];
                CFG_BYTE_SWAP:     r_cfg.byte_swap     <= i_cfg_data[0];
                CFG_IQ_SWAP:       r_cfg.iq_swap       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // packet length in words, at least one and at most the limit
    always_comb begin
        if (r_cfg.decode_mode == MODE_RAW) begin
            bytes = PKT_LEN_W'(r_cfg.payload_bytes);
        end else begin
            bytes = PKT_LEN_W'(r_cfg.header_bytes) + PKT_LEN_W'(r_cfg.payload_bytes)
                  + PKT_LEN_W'(r_cfg.tail_bytes);
        end
        words = {2'b00, bytes[PKT_LEN_W-1:2]};
        if (words == '0) begin
            n_pkt_words = PKT_LEN_W'(1);
        end else if (words > PKT_LEN_W'(MAX_PACKET_WORDS)) begin
            n_pkt_words = PKT_LEN_W'(MAX_PACKET_WORDS);
        end else begin
            n_pkt_words = words;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_words <= PKT_LEN_W'(1);
        end else begin
            r_pkt_words <= n_pkt_words;
        end
    end

    vpd_in_skid u_in_skid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_valid       (word_valid),
        .o_word        (word),
        .i_ready       (word_ready)
    );

    vpd_decode #(
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pkt_words  (r_pkt_words),
        .i_word_valid (word_valid),
        .i_word       (word),
        .o_word_ready (word_ready),
        .o_bun        (bun),
        .i_bun_free   (bun_free)
    );

    vpd_out_emit u_out_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bun         (bun),
        .o_free        (bun_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/vpd_in_skid.sv =====
// input skid stage of the deframer: main beat register plus one spare
// depends on vpd_pkg and vita49_packet_deframer_defines.svh
`include "vita49_packet_deframer_defines.svh"

module vpd_in_skid (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [vpd_pkg::WORD_W-1:0] s_axis_tdata,   // [31:0] data_word
    output logic                       o_valid,
    output logic [vpd_pkg::WORD_W-1:0] o_word,
    input  logic                       i_ready
);
    import vpd_pkg::*;

    logic              r_main_valid;
    logic              r_skid_valid;
    logic [WORD_W-1:0] r_main;
    logic [WORD_W-1:0] r_skid;
    logic              accept;
    logic              pop;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && !r_skid_valid;
    assign pop           = r_main_valid && i_ready;
    assign o_valid       = r_main_valid;
    assign o_word        = r_main;

    // control: main holds the oldest beat, spare only fills when main stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (accept) begin
                if (r_main_valid && !pop) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_main_valid <= 1'b1;
                end
            end else if (pop) begin
                r_main_valid <= 1'b0;
            end
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (accept) begin
            if (r_main_valid && !pop) begin
                r_skid <= s_axis_tdata;
            end else begin
                r_main <= s_axis_tdata;
            end
        end
    end

    `VPD_ASSERT_NOW(a_skid_behind_main, r_skid_valid, r_main_valid, "spare beat without main beat")

endmodule

// ===== hw/rtl/vpd_decode.sv =====
// word decoder: packet position, header sequencer and result bundle build
// depends on vpd_pkg and vita49_packet_deframer_defines.svh
`include "vita49_packet_deframer_defines.svh"

module vpd_decode #(
    parameter int unsigned MAX_PACKET_WORDS = vpd_pkg::MAX_PACKET_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vpd_pkg::t_cfg                 i_cfg,
    input  logic [vpd_pkg::PKT_LEN_W-1:0] i_pkt_words,
    input  logic                          i_word_valid,
    input  logic [vpd_pkg::WORD_W-1:0]    i_word,
    output logic                          o_word_ready,
    output vpd_pkg::t_bundle              o_bun,
    input  logic                          i_bun_free
);
    import vpd_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_PACKET_WORDS);
    localparam logic [SAMPLES_W-1:0] SKIP_WORDS = SAMPLES_W'(5);

    typedef enum logic [3:0] {
        ST_ALIGN, ST_FRAME, ST_HDR, ST_STREAM, ST_OUI, ST_CLASS, ST_TSI,
        ST_TSF_HI, ST_TSF_LO, ST_SKIP, ST_PAYLOAD, ST_TRAILER, ST_DONE
    } t_step;

    typedef struct packed {
        logic cls;
        logic trl;
        logic tsi;
        logic tsf;
        logic sid;
    } t_flags;

    typedef struct packed {
        t_step                step;
        logic                 load;
        logic [SAMPLES_W-1:0] samples;
    } t_ent;

    // move to step s or the first later step this packet has
    function automatic t_ent f_enter(input t_step s, input t_flags f, input logic plain,
                                     input logic [SAMPLES_W-1:0] pl);
        t_ent  r;
        t_step x;
        logic  hit;
        r.load    = 1'b0;
        r.samples = '0;
        x         = s;
        hit       = 1'b0;
        if (x == ST_STREAM) begin
            if (f.sid) hit = 1'b1; else x = ST_OUI;
        end
        if (!hit && x == ST_OUI) begin
            if (f.cls) hit = 1'b1; else x = ST_TSI;
        end
        if (!hit && x == ST_TSI) begin
            if (f.tsi) hit = 1'b1; else x = ST_TSF_HI;
        end
        if (!hit && x == ST_TSF_HI) begin
            if (f.tsf) hit = 1'b1; else x = ST_SKIP;
        end
        if (!hit && x == ST_SKIP) begin
            if (plain) begin
                hit       = 1'b1;
                r.load    = 1'b1;
                r.samples = SKIP_WORDS;
            end else begin
                x = ST_PAYLOAD;
            end
        end
        if (!hit && x == ST_PAYLOAD) begin
            r.load    = 1'b1;
            r.samples = pl;
            if (pl != '0) hit = 1'b1; else x = ST_TRAILER;
        end
        if (!hit && x == ST_TRAILER && !f.trl) begin
            x = ST_DONE;
        end
        r.step = x;
        return r;
    endfunction

    t_step                r_step;
    logic [POS_W-1:0]     r_pos;
    t_flags               r_flags;
    logic [SAMPLES_W-1:0] r_samples;
    logic [WORD_W-1:0]    r_frac;

    t_step                n_step;
    logic [POS_W-1:0]     n_pos;
    t_flags               n_flags;
    logic [SAMPLES_W-1:0] n_samples;
    logic [WORD_W-1:0]    n_frac;

    logic [WORD_W-1:0]    w;
    logic                 first;
    logic                 plain;
    logic [SAMPLES_W-1:0] pl;
    t_step                cur;
    t_ent                 ent_first;
    t_ent                 ent;
    logic                 do_enter;
    t_step                enter_from;
    logic [SAMPLES_W-1:0] dec;
    logic [RES_CNT_W-1:0] nres;
    logic [PKT_LEN_W-1:0] pos_next;
    logic                 fire;

    logic [MAX_RESULTS-1:0][KIND_W-1:0]  kind;
    logic [MAX_RESULTS-1:0][VALUE_W-1:0] value;
    logic signed [SAMPLE_W-1:0]          si;
    logic signed [SAMPLE_W-1:0]          sq;

    // decode one word into results and next state
    always_comb begin
        w     = i_cfg.byte_swap ? f_byte_swap(i_word) : i_word;
        first = (r_pos == '0);
        plain = (i_cfg.decode_mode == MODE_PLAIN);
        pl    = i_cfg.payload_bytes[15:2];

        n_flags   = first ? '0 : r_flags;
        n_samples = r_samples;
        n_frac    = r_frac;
        ent_first = f_enter(ST_PAYLOAD, '0, plain, pl);

        // start of packet picks the entry step from the mode
        if (first) begin
            case (i_cfg.decode_mode)
                MODE_RAW: begin
                    cur       = ent_first.step;
                    n_samples = ent_first.samples;
                end
                MODE_PLAIN: cur = ST_HDR;
                default:    cur = ST_ALIGN;
            endcase
        end else begin
            cur = r_step;
        end

        n_step     = cur;
        kind       = '0;
        value      = '0;
        si         = '0;
        sq         = '0;
        nres       = '0;
        do_enter   = 1'b0;
        enter_from = ST_DONE;
        dec        = n_samples;

        case (cur)
            ST_ALIGN: begin
                kind[0]  = KIND_ALIGN;
                value[0] = VALUE_W'(w);
                nres     = RES_CNT_W'(1);
                n_step   = ST_FRAME;
            end
            ST_FRAME: begin
                kind[0]  = KIND_FRAME_CNT;
                value[0] = VALUE_W'(w[31:20]);
                kind[1]  = KIND_FRAME_SIZE;
                value[1] = VALUE_W'(w[19:0]);
                nres     = RES_CNT_W'(2);
                n_step   = ST_HDR;
            end
            ST_HDR: begin
                n_flags.cls = w[27];
                n_flags.trl = w[26];
                n_flags.tsi = (w[23:22] != 2'b00);
                n_flags.tsf = (w[21:20] != 2'b00);
                n_flags.sid = plain || (w[31:28] == 4'd1) || (w[31:28] == 4'd3);
                kind[0]  = KIND_TYPE;
                value[0] = VALUE_W'(w[31:28]);
                kind[1]  = KIND_CLASS_FLAG;
                value[1] = VALUE_W'(w[27]);
                kind[2]  = KIND_TRAIL_FLAG;
                value[2] = VALUE_W'(w[26]);
                kind[3]  = KIND_TSI_TYPE;
                value[3] = VALUE_W'(w[23:22]);
                kind[4]  = KIND_TSF_TYPE;
                value[4] = VALUE_W'(w[21:20]);
                kind[5]  = KIND_PKT_CNT;
                value[5] = VALUE_W'(w[19:16]);
                kind[6]  = KIND_PKT_SIZE;
                value[6] = VALUE_W'(w[15:0]);
                nres       = RES_CNT_W'(7);
                do_enter   = 1'b1;
                enter_from = ST_STREAM;
            end
            ST_STREAM: begin
                kind[0]    = KIND_STREAM;
                value[0]   = VALUE_W'(w);
                nres       = RES_CNT_W'(1);
                do_enter   = 1'b1;
                enter_from = ST_OUI;
            end
            ST_OUI: begin
                kind[0]  = KIND_OUI;
                value[0] = VALUE_W'(w[27:0]);
                nres     = RES_CNT_W'(1);
                n_step   = ST_CLASS;
            end
            ST_CLASS: begin
                kind[0]    = KIND_ICC;
                value[0]   = VALUE_W'(w[31:16]);
                kind[1]    = KIND_PCC;
                value[1]   = VALUE_W'(w[15:0]);
                nres       = RES_CNT_W'(2);
                do_enter   = 1'b1;
                enter_from = ST_TSI;
            end
            ST_TSI: begin
                kind[0]    = KIND_TS_INT;
                value[0]   = VALUE_W'(w);
                nres       = RES_CNT_W'(1);
                do_enter   = 1'b1;
                enter_from = ST_TSF_HI;
            end
            ST_TSF_HI: begin
                n_frac = w;
                n_step = ST_TSF_LO;
            end
            ST_TSF_LO: begin
                kind[0]    = KIND_TS_FRAC;
                value[0]   = {r_frac, w};
                nres       = RES_CNT_W'(1);
                do_enter   = 1'b1;
                enter_from = ST_SKIP;
            end
            ST_SKIP: begin
                if (dec != '0) dec = dec - SAMPLES_W'(1);
                n_samples = dec;
                if (dec == '0) begin
                    do_enter   = 1'b1;
                    enter_from = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                kind[0] = KIND_SAMPLE;
                if (i_cfg.iq_swap) begin
                    si = w[15:0];
                    sq = w[31:16];
                end else begin
                    si = w[31:16];
                    sq = w[15:0];
                end
                nres = RES_CNT_W'(1);
                if (dec != '0) dec = dec - SAMPLES_W'(1);
                n_samples = dec;
                if (dec == '0) begin
                    do_enter   = 1'b1;
                    enter_from = ST_TRAILER;
                end
            end
            ST_TRAILER: begin
                kind[0]  = KIND_TRAILER;
                value[0] = VALUE_W'(w);
                nres     = RES_CNT_W'(1);
                n_step   = ST_DONE;
            end
            default: begin
                n_step = cur;
            end
        endcase

        ent = f_enter(enter_from, n_flags, plain, pl);
        if (do_enter) begin
            n_step = ent.step;
            if (ent.load) n_samples = ent.samples;
        end

        // packet end mark after the word's own results
        pos_next = PKT_LEN_W'(r_pos) + PKT_LEN_W'(1);
        if (pos_next >= i_pkt_words) begin
            kind[nres[RES_IDX_W-1:0]]  = KIND_END;
            value[nres[RES_IDX_W-1:0]] = '0;
            nres  = nres + RES_CNT_W'(1);
            n_pos = '0;
        end else begin
            n_pos = pos_next[POS_W-1:0];
        end
    end

    // words without results need no room downstream
    assign o_word_ready = i_bun_free || (nres == '0);
    assign fire         = i_word_valid && o_word_ready;

    always_comb begin
        o_bun.load     = fire && (nres != '0);
        o_bun.last_idx = RES_IDX_W'(nres - RES_CNT_W'(1));
        o_bun.kind     = kind;
        o_bun.value    = value;
        o_bun.sample_i = si;
        o_bun.sample_q = sq;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_ALIGN;
            r_pos     <= '0;
            r_flags   <= '0;
            r_samples <= '0;
            r_frac    <= '0;
        end else if (fire) begin
            r_step    <= n_step;
            r_pos     <= n_pos;
            r_flags   <= n_flags;
            r_samples <= n_samples;
            r_frac    <= n_frac;
        end
    end

    `VPD_ASSERT_NOW(a_payload_has_samples, r_step == ST_PAYLOAD, r_samples != '0, "payload step with no samples left")
    `VPD_ASSERT_NOW(a_skip_count_range, r_step == ST_SKIP, (r_samples != '0) && (r_samples <= SKIP_WORDS), "skip count out of range")

endmodule

// ===== hw/rtl/vpd_out_emit.sv =====
// result register and output serialiser: one result beat per cycle while m_axis_tready is high
// depends on vpd_pkg and vita49_packet_deframer_defines.svh
`include "vita49_packet_deframer_defines.svh"

module vpd_out_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vpd_pkg::t_bundle               i_bun,
    output logic                           o_free,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [vpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [vpd_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import vpd_pkg::*;

    logic                                r_valid;
    logic [RES_IDX_W-1:0]                r_idx;
    logic [RES_IDX_W-1:0]                r_last_idx;
    logic [MAX_RESULTS-1:0][KIND_W-1:0]  r_kind;
    logic [MAX_RESULTS-1:0][VALUE_W-1:0] r_value;
    logic signed [SAMPLE_W-1:0]          r_si;
    logic signed [SAMPLE_W-1:0]          r_sq;

    logic        at_last;
    logic        is_sample;
    t_kind       cur_kind;

    assign at_last   = (r_idx == r_last_idx);
    assign o_free    = !r_valid || (m_axis_tready && at_last);
    assign cur_kind  = r_kind[r_idx];
    assign is_sample = (cur_kind == KIND_SAMPLE);

    // output beat from the held bundle
    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = cur_kind;
    assign m_axis_tlast  = at_last;
    assign m_axis_tdata  = {(is_sample ? r_sq : '0), (is_sample ? r_si : '0), r_value[r_idx]};

    // control: load a new bundle or step through the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_bun.load && o_free) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && m_axis_tready) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + RES_IDX_W'(1);
            end
        end
    end

    // bundle payload
    always_ff @(posedge i_clk) begin
        if (i_bun.load && o_free) begin
            r_last_idx <= i_bun.last_idx;
            r_kind     <= i_bun.kind;
            r_value    <= i_bun.value;
            r_si       <= i_bun.sample_i;
            r_sq       <= i_bun.sample_q;
        end
    end

    `VPD_ASSERT_NOW(a_idx_in_bundle, r_valid, r_idx <= r_last_idx, "result index past bundle end")
    `VPD_ASSERT_NOW(a_no_overwrite, i_bun.load && r_valid, m_axis_tready && at_last, "bundle loaded over pending results")
    `VPD_ASSERT_NEXT(a_idx_steps, r_valid && m_axis_tready && !at_last, r_valid && (r_idx == $past(r_idx) + RES_IDX_W'(1)), "result index did not advance")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench for vita49_packet_deframer: directed packets, backpressure and random traffic
// checked beat by beat against a cycle-free predictor; depends on vpd_pkg and the rtl
module tb;
    import vpd_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 600000;
    localparam int unsigned RANDOM_ITEMS  = 330;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned MAX_PRINTS    = 40;

    // unused mode code, decoded as framed
    localparam t_mode MODE_SPARE = 2'd3;
    // packet types that carry a stream id
    localparam logic [3:0] PTYPE_SIG_STREAM = 4'd1;
    localparam logic [3:0] PTYPE_EXT_STREAM = 4'd3;

    typedef enum logic [3:0] {
        DS_ALIGN, DS_FRAME, DS_HDR, DS_STREAM, DS_OUI, DS_CLASS, DS_TSI,
        DS_TSF_HI, DS_TSF_LO, DS_SKIP, DS_PAYLOAD, DS_TRAILER, DS_DONE
    } t_step;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
        logic [SAMPLE_W-1:0] si;
        logic [SAMPLE_W-1:0] sq;
        logic                last;
    } t_field;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata  = '0;   // [31:0] data_word
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [63:0] field_value, [79:64] sample_i, [95:80] sample_q
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;         // [4:0] field_kind
    logic                  m_axis_tlast;

    vita49_packet_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the configuration
    t_mode       cfg_mode    = MODE_RAW;
    logic [8:0]  cfg_header  = '0;
    logic [15:0] cfg_payload = '0;
    logic [8:0]  cfg_tail    = '0;
    logic        cfg_bswap   = 1'b0;
    logic        cfg_iqswap  = 1'b0;

    // predictor copy of the decode state
    int unsigned pkt_pos     = 0;
    t_step       dec_step    = DS_ALIGN;
    logic        has_class   = 1'b0;
    logic        has_trailer = 1'b0;
    logic        has_tsi     = 1'b0;
    logic        has_tsf     = 1'b0;
    logic        has_stream  = 1'b0;
    logic [31:0] frac_hi     = '0;
    int unsigned words_left  = 0;

    t_field      word_fields[$];
    t_field      expected_fields[$];

    int unsigned mismatch_count = 0;
    int unsigned src_max        = 0;
    int unsigned sink_max       = 0;
    int unsigned hold_seq       = 0;
    int unsigned cycle_count    = 0;
    int unsigned beat_count     = 0;

    function automatic logic [31:0] swap_bytes(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // packet length in words from the current settings
    function automatic int unsigned packet_len();
        int unsigned bytes;
        int unsigned words;
        bytes = (cfg_mode == MODE_RAW) ? 32'(cfg_payload)
                                       : 32'(cfg_header) + 32'(cfg_payload) + 32'(cfg_tail);
        words = bytes >> 2;
        if (words == 0) words = 1;
        if (words > MAX_PACKET_WORDS_DEF) words = MAX_PACKET_WORDS_DEF;
        return words;
    endfunction

    function automatic void add_field(input t_kind kind, input logic [VALUE_W-1:0] value,
                                      input logic [SAMPLE_W-1:0] si,
                                      input logic [SAMPLE_W-1:0] sq);
        t_field f;
        f.kind  = kind;
        f.value = value;
        f.si    = si;
        f.sq    = sq;
        f.last  = 1'b0;
        word_fields.push_back(f);
    endfunction

    // move to the given step or the first later one present in this packet
    function automatic void seek_step(input t_step start);
        t_step s;
        bit    found;
        s     = start;
        found = 1'b0;
        while (!found) begin
            case (s)
                DS_STREAM: if (has_stream) found = 1'b1; else s = DS_OUI;
                DS_OUI:    if (has_class) found = 1'b1; else s = DS_TSI;
                DS_TSI:    if (has_tsi) found = 1'b1; else s = DS_TSF_HI;
                DS_TSF_HI: if (has_tsf) found = 1'b1; else s = DS_SKIP;
                DS_SKIP: begin
                    if (cfg_mode == MODE_PLAIN) begin
                        words_left = 5;
                        found      = 1'b1;
                    end else begin
                        s = DS_PAYLOAD;
                    end
                end
                DS_PAYLOAD: begin
                    words_left = 32'(cfg_payload[15:2]);
                    if (words_left != 0) found = 1'b1; else s = DS_TRAILER;
                end
                DS_TRAILER: if (has_trailer) found = 1'b1; else s = DS_DONE;
                default: found = 1'b1;
            endcase
        end
        dec_step = s;
    endfunction

    // expected fields for one accepted packet word
    function automatic void decode_word(input logic [31:0] raw);
        logic [31:0]  w;
        int unsigned  len;
        t_field       f;
        len = packet_len();
        w   = cfg_bswap ? swap_bytes(raw) : raw;
        word_fields.delete();

        // start of packet: clear flags and pick the first step for the mode
        if (pkt_pos == 0) begin
            has_class   = 1'b0;
            has_trailer = 1'b0;
            has_tsi     = 1'b0;
            has_tsf     = 1'b0;
            has_stream  = 1'b0;
            if (cfg_mode == MODE_RAW) seek_step(DS_PAYLOAD);
            else if (cfg_mode == MODE_PLAIN) dec_step = DS_HDR;
            else dec_step = DS_ALIGN;
        end

        case (dec_step)
            DS_ALIGN: begin
                add_field(KIND_ALIGN, 64'(w), '0, '0);
                dec_step = DS_FRAME;
            end
            DS_FRAME: begin
                add_field(KIND_FRAME_CNT, 64'(w[31:20]), '0, '0);
                add_field(KIND_FRAME_SIZE, 64'(w[19:0]), '0, '0);
                dec_step = DS_HDR;
            end
            DS_HDR: begin
                has_class   = w[27];
                has_trailer = w[26];
                has_tsi     = |w[23:22];
                has_tsf     = |w[21:20];
                has_stream  = (cfg_mode == MODE_PLAIN) || (w[31:28] == PTYPE_SIG_STREAM)
                              || (w[31:28] == PTYPE_EXT_STREAM);
                add_field(KIND_TYPE, 64'(w[31:28]), '0, '0);
                add_field(KIND_CLASS_FLAG, 64'(w[27]), '0, '0);
                add_field(KIND_TRAIL_FLAG, 64'(w[26]), '0, '0);
                add_field(KIND_TSI_TYPE, 64'(w[23:22]), '0, '0);
                add_field(KIND_TSF_TYPE, 64'(w[21:20]), '0, '0);
                add_field(KIND_PKT_CNT, 64'(w[19:16]), '0, '0);
                add_field(KIND_PKT_SIZE, 64'(w[15:0]), '0, '0);
                seek_step(DS_STREAM);
            end
            DS_STREAM: begin
                add_field(KIND_STREAM, 64'(w), '0, '0);
                seek_step(DS_OUI);
            end
            DS_OUI: begin
                add_field(KIND_OUI, 64'(w[27:0]), '0, '0);
                dec_step = DS_CLASS;
            end
            DS_CLASS: begin
                add_field(KIND_ICC, 64'(w[31:16]), '0, '0);
                add_field(KIND_PCC, 64'(w[15:0]), '0, '0);
                seek_step(DS_TSI);
            end
            DS_TSI: begin
                add_field(KIND_TS_INT, 64'(w), '0, '0);
                seek_step(DS_TSF_HI);
            end
            DS_TSF_HI: begin
                frac_hi  = w;
                dec_step = DS_TSF_LO;
            end
            DS_TSF_LO: begin
                add_field(KIND_TS_FRAC, {frac_hi, w}, '0, '0);
                seek_step(DS_SKIP);
            end
            DS_SKIP: begin
                if (words_left > 0) words_left--;
                if (words_left == 0) seek_step(DS_PAYLOAD);
            end
            DS_PAYLOAD: begin
                if (cfg_iqswap) add_field(KIND_SAMPLE, '0, w[15:0], w[31:16]);
                else add_field(KIND_SAMPLE, '0, w[31:16], w[15:0]);
                if (words_left > 0) words_left--;
                if (words_left == 0) seek_step(DS_TRAILER);
            end
            DS_TRAILER: begin
                add_field(KIND_TRAILER, 64'(w), '0, '0);
                dec_step = DS_DONE;
            end
            default: ;
        endcase

        pkt_pos++;
        if (pkt_pos >= len) begin
            add_field(KIND_END, '0, '0, '0);
            pkt_pos = 0;
        end

        // the final field of this word closes the run
        foreach (word_fields[n]) begin
            f      = word_fields[n];
            f.last = (n == word_fields.size() - 1);
            expected_fields.push_back(f);
        end
    endfunction

    task automatic report_error(input string msg);
        if (mismatch_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one register write, mirrored into the predictor
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DECODE_MODE:   cfg_mode    = data[1:0];
            CFG_HEADER_BYTES:  cfg_header  = data[8:0];
            CFG_PAYLOAD_BYTES: cfg_payload = data[15:0];
            CFG_TAIL_BYTES:    cfg_tail    = data[8:0];
            CFG_BYTE_SWAP:     cfg_bswap   = data[0];
            CFG_IQ_SWAP:       cfg_iqswap  = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_mode mode, input logic [15:0] hdr, input logic [15:0] pay,
                              input logic [15:0] tail, input logic bswap, input logic iq);
        cfg_write(CFG_DECODE_MODE, {14'd0, mode});
        cfg_write(CFG_HEADER_BYTES, hdr);
        cfg_write(CFG_PAYLOAD_BYTES, pay);
        cfg_write(CFG_TAIL_BYTES, tail);
        cfg_write(CFG_BYTE_SWAP, {15'd0, bswap});
        cfg_write(CFG_IQ_SWAP, {15'd0, iq});
        // let the registered packet length follow
        repeat (4) @(posedge i_clk);
    endtask

    // offer one word after a random gap and predict once it is taken
    task automatic send_word(input logic [31:0] w);
        int unsigned gap;
        gap = $urandom_range(0, src_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_word(w);
    endtask

    // stop offering and wait until every expected beat has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // reset settings give raw mode with no payload, so each word is a packet
    task automatic test_zero_length_packet();
        send_word(32'h0000_0001);
        send_word(32'hFFFF_FFFF);
        drain_results();
    endtask

    // every header field once, spare mode code, header size written too wide
    task automatic test_framed_header_fields();
        logic [31:0] words[$];
        set_config(MODE_SPARE, 16'hFE24, 16'd8, 16'd4, 1'b0, 1'b1);
        words = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h1CF5_ABCD, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h8000_7FFF, 32'h7FFF_8000, 32'hA5A5_A5A5};
        foreach (words[n]) send_word(words[n]);
        drain_results();
    endtask

    // plain mode, byte swapped, packet ends inside the header
    task automatic test_plain_short_packet();
        logic [31:0] words[$];
        set_config(MODE_PLAIN, 16'd8, 16'd4, 16'd8, 1'b1, 1'b0);
        words = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
                  32'h7FFF_FFFF};
        foreach (words[n]) send_word(swap_bytes(words[n]));
        drain_results();
    endtask

    // settings change between words of one packet, padding after the sample
    task automatic test_config_within_packet();
        set_config(MODE_FRAMED, 16'd12, 16'd4, 16'd8, 1'b0, 1'b0);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h2000_0000);
        drain_results();
        cfg_write(CFG_IQ_SWAP, 16'd1);
        cfg_write(CFG_TAIL_BYTES, 16'd4);
        repeat (4) @(posedge i_clk);
        send_word(32'hFFFF_0000);
        send_word(32'h5A5A_5A5A);
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_hold();
        set_config(MODE_RAW, 16'd0, 16'd160, 16'd0, 1'b0, 1'b1);
        src_max  = 0;
        sink_max = 0;
        hold_seq++;
        repeat (80) send_word($urandom);
        drain_results();
    endtask

    // phases of random settings, mostly well-formed packets with random content
    task automatic test_random_packets();
        int unsigned sent;
        int unsigned n_pkts;
        int unsigned n_samp;
        int unsigned hdr_words;
        int unsigned hdr_b;
        int unsigned pay_b;
        int unsigned tail_b;
        int unsigned len;
        int unsigned hdr_at;
        int unsigned pick;
        t_mode       mode;
        logic [3:0]  ptype;
        logic        cls;
        logic        trl;
        logic        bswap;
        logic        iq;
        logic [1:0]  tsi;
        logic [1:0]  tsf;
        logic        streamed;
        logic        framed;
        logic [31:0] hdr_word;
        logic [31:0] w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // settings of this phase
            pick   = $urandom_range(0, 9);
            mode   = (pick < 2) ? MODE_RAW : (pick < 5) ? MODE_FRAMED
                   : (pick < 9) ? MODE_PLAIN : MODE_SPARE;
            framed = (mode == MODE_FRAMED) || (mode == MODE_SPARE);
            ptype  = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 1)) ptype = $urandom_range(0, 1) ? PTYPE_SIG_STREAM
                                                                   : PTYPE_EXT_STREAM;
            cls      = 1'($urandom_range(0, 1));
            trl      = 1'($urandom_range(0, 1));
            tsi      = 2'($urandom_range(0, 3));
            tsf      = 2'($urandom_range(0, 3));
            bswap    = 1'($urandom_range(0, 1));
            iq       = 1'($urandom_range(0, 1));
            streamed = (mode == MODE_PLAIN) || (ptype == PTYPE_SIG_STREAM)
                       || (ptype == PTYPE_EXT_STREAM);
            hdr_words = 1 + (streamed ? 1 : 0) + (cls ? 2 : 0) + ((tsi != 0) ? 1 : 0)
                        + ((tsf != 0) ? 2 : 0) + (mode == MODE_PLAIN ? 5 : 0)
                        + (framed ? 2 : 0);
            n_samp = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            hdr_b  = hdr_words * 4;
            if ($urandom_range(0, 7) == 0) hdr_b += $urandom_range(0, 7);
            pay_b  = (mode == MODE_RAW) ? $urandom_range(0, 64)
                                        : n_samp * 4 + $urandom_range(0, 3);
            tail_b = trl ? 4 : 0;
            if ($urandom_range(0, 5) == 0) tail_b += $urandom_range(1, 12);
            set_config(mode, 16'(hdr_b), 16'(pay_b), 16'(tail_b), bswap, iq);

            src_max  = ($urandom_range(0, 3) == 0) ? 0 : 12;
            sink_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            hdr_at   = framed ? 2 : 0;
            n_pkts   = $urandom_range(2, 5);

            for (int p = 0; p < n_pkts; p++) begin
                len      = packet_len();
                hdr_word = $urandom;
                // some headers are left as noise
                if ($urandom_range(0, 7) != 0) begin
                    hdr_word[31:28] = ptype;
                    hdr_word[27]    = cls;
                    hdr_word[26]    = trl;
                    hdr_word[23:22] = tsi;
                    hdr_word[21:20] = tsf;
                end
                for (int k = 0; k < len; k++) begin
                    w = (mode != MODE_RAW && k == hdr_at) ? hdr_word : $urandom;
                    send_word(bswap ? swap_bytes(w) : w);
                end
                sent += len;
            end
            drain_results();
        end
    endtask

    // widest settings: length clipped to the largest packet, then the packet is
    // cut short by shrinking the length while it is open
    task automatic test_overlong_packet();
        set_config(MODE_PLAIN, 16'hFFFF, 16'hFFFC, 16'hFFFF, 1'b1, 1'b0);
        src_max  = 0;
        sink_max = 0;
        send_word(32'h0000_0000);
        repeat (15) send_word($urandom);
        drain_results();
        cfg_write(CFG_HEADER_BYTES, 16'd0);
        cfg_write(CFG_PAYLOAD_BYTES, 16'd0);
        cfg_write(CFG_TAIL_BYTES, 16'd0);
        repeat (4) @(posedge i_clk);
        send_word($urandom);
        drain_results();
    endtask

    // result side: random stalls between beats, long hold on request
    always @(posedge i_clk) begin : result_sink
        int unsigned gap_left;
        int unsigned hold_seen;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            gap_left  = 0;
            hold_seen = hold_seq;
        end else begin
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                gap_left  = HOLD_CYCLES;
            end else if (m_axis_tvalid && m_axis_tready) begin
                gap_left = $urandom_range(0, sink_max);
            end else if (gap_left > 0) begin
                gap_left--;
            end
            m_axis_tready <= (gap_left == 0);
        end
    end

    // compare each output beat with the oldest expected field
    always @(posedge i_clk) begin : check_results
        t_field              want;
        logic [VALUE_W-1:0]  got_value;
        logic [SAMPLE_W-1:0] got_i;
        logic [SAMPLE_W-1:0] got_q;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_value = m_axis_tdata[VALUE_W-1:0];
            got_i     = m_axis_tdata[VALUE_W +: SAMPLE_W];
            got_q     = m_axis_tdata[VALUE_W + SAMPLE_W +: SAMPLE_W];
            if (expected_fields.size() == 0) begin
                report_error($sformatf("beat %0d unexpected: kind %0d value %h",
                                       beat_count, m_axis_tuser, got_value));
            end else begin
                want = expected_fields.pop_front();
                if (m_axis_tuser != want.kind)
                    report_error($sformatf("beat %0d kind %0d, want %0d",
                                           beat_count, m_axis_tuser, want.kind));
                if (got_value != want.value)
                    report_error($sformatf("beat %0d kind %0d value %h, want %h",
                                           beat_count, want.kind, got_value, want.value));
                if (got_i != want.si)
                    report_error($sformatf("beat %0d sample_i %h, want %h",
                                           beat_count, got_i, want.si));
                if (got_q != want.sq)
                    report_error($sformatf("beat %0d sample_q %h, want %h",
                                           beat_count, got_q, want.sq));
                if (m_axis_tlast != want.last)
                    report_error($sformatf("beat %0d kind %0d tlast %b, want %b",
                                           beat_count, want.kind, m_axis_tlast, want.last));
            end
            beat_count++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        src_max  = 12;
        sink_max = 12;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length_packet();
        test_framed_header_fields();
        test_plain_short_packet();
        test_config_within_packet();
        test_output_hold();
        test_random_packets();
        test_overlong_packet();

        drain_results();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vpd_pkg.sv
hw/rtl/vpd_in_skid.sv
hw/rtl/vpd_decode.sv
hw/rtl/vpd_out_emit.sv
hw/rtl/vita49_packet_deframer.sv
tb/tb.sv
